/* rtl/hsfc_pkg.sv */
// Package for the humidity sensor frame checker: codes, frame positions, constants and CRC step.
package hsfc_pkg;

    // Event code carried with each received item.
    typedef enum logic [1:0] {
        OP_DATA       = 2'd0,
        OP_NOT_READY  = 2'd1,
        OP_SEND_FAIL  = 2'd2,
        OP_RECV_FAIL  = 2'd3
    } t_opcode;

    // Status reported with each frame result.
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOT_READY = 3'd1,
        ST_SEND_ERR  = 3'd2,
        ST_RECV_ERR  = 3'd3,
        ST_CRC_ERR   = 3'd4
    } t_status;

    // Byte positions within one six-byte response.
    localparam logic [2:0] POS_TEMP_MSB = 3'd0;
    localparam logic [2:0] POS_TEMP_LSB = 3'd1;
    localparam logic [2:0] POS_TEMP_CRC = 3'd2;
    localparam logic [2:0] POS_HUM_MSB  = 3'd3;
    localparam logic [2:0] POS_HUM_LSB  = 3'd4;

    // CRC-8 parameters: polynomial x^8 + x^5 + x^4 + 1, no reflection, no final XOR.
    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [7:0] CRC_POLY = 8'h31;

    // Conversion constants: full scale of the raw words and the output spans.
    localparam logic [16:0] WORD_FULL    = 17'd65535;
    localparam logic [14:0] TEMP_SPAN    = 15'd17500;
    localparam logic [14:0] TEMP_OFFSET  = 15'd4500;
    localparam logic [13:0] HUM_SPAN     = 14'd10000;

    // Fold one byte into the running CRC, eight shift steps, MSB first.
    function automatic logic [7:0] crc8_fold(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

/* rtl/humidity_sensor_frame_checker.sv */
// Top level of the humidity sensor frame checker: frame tracking, CRC checks and conversion.
// A result reaches the master side through the input register, stage 1, stage 2 and the output
// register after the transfer that closes the frame (the sixth byte or an error event).
// Throughput: one input transfer per cycle; the pipeline stalls as a whole only
// while a result sits in the output register and the downstream side is not ready.
// Reset: synchronous, active low; clears frame position, CRC, check flag and stage valids.
module humidity_sensor_frame_checker
    import hsfc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  logic [1:0]  i_s_axis_tuser,   // [1:0] opcode
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // [14:0] temperature_centi, [28:15] humidity_centi
    output logic [2:0]  o_m_axis_tuser    // [2:0] status
);

    // Output register.
    logic        r_out_valid;
    t_status     r_out_status;
    logic [14:0] r_out_temp;
    logic [13:0] r_out_hum;

    // The whole pipeline advances whenever the output register is free or being taken.
    logic w_en;
    assign w_en            = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = w_en;

    // Input register.
    logic       r_in_valid;
    t_opcode    r_in_op;
    logic [7:0] r_in_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_en) begin
            r_in_valid <= i_s_axis_tvalid;
        end
        if (w_en) begin
            r_in_op   <= t_opcode'(i_s_axis_tuser);
            r_in_byte <= i_s_axis_tdata;
        end
    end

    // Frame state.
    logic [2:0]  r_pos, n_pos;
    logic [7:0]  r_crc, n_crc;
    logic [15:0] r_tword, n_tword;
    logic [15:0] r_hword, n_hword;
    logic        r_first_ok, n_first_ok;
    logic        n_emit;
    t_status     n_status;

    // Frame tracking for the item held in the input register.
    always_comb begin
        n_pos      = r_pos;
        n_crc      = r_crc;
        n_tword    = r_tword;
        n_hword    = r_hword;
        n_first_ok = r_first_ok;
        n_emit     = 1'b0;
        n_status   = ST_OK;
        if (r_in_valid) begin
            if (r_in_op != OP_DATA) begin
                // A bus error event ends the frame with its own status.
                n_pos      = POS_TEMP_MSB;
                n_crc      = CRC_INIT;
                n_first_ok = 1'b0;
                n_emit     = 1'b1;
                unique case (r_in_op)
                    OP_NOT_READY: n_status = ST_NOT_READY;
                    OP_SEND_FAIL: n_status = ST_SEND_ERR;
                    default:      n_status = ST_RECV_ERR;
                endcase
            end else begin
                unique case (r_pos)
                    POS_TEMP_MSB, POS_TEMP_LSB: begin
                        n_tword = {r_tword[7:0], r_in_byte};
                        n_crc   = crc8_fold(r_crc, r_in_byte);
                        n_pos   = r_pos + 3'd1;
                    end
                    POS_HUM_MSB, POS_HUM_LSB: begin
                        n_hword = {r_hword[7:0], r_in_byte};
                        n_crc   = crc8_fold(r_crc, r_in_byte);
                        n_pos   = r_pos + 3'd1;
                    end
                    POS_TEMP_CRC: begin
                        n_first_ok = (r_crc == r_in_byte);
                        n_crc      = CRC_INIT;
                        n_pos      = POS_HUM_MSB;
                    end
                    default: begin
                        // Last byte, or any stray position: close the frame.
                        n_emit     = 1'b1;
                        n_status   = (r_first_ok && (r_crc == r_in_byte)) ? ST_OK : ST_CRC_ERR;
                        n_pos      = POS_TEMP_MSB;
                        n_crc      = CRC_INIT;
                        n_first_ok = 1'b0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= POS_TEMP_MSB;
            r_crc      <= CRC_INIT;
            r_first_ok <= 1'b0;
        end else if (w_en) begin
            r_pos      <= n_pos;
            r_crc      <= n_crc;
            r_first_ok <= n_first_ok;
        end
        if (w_en) begin
            r_tword <= n_tword;
            r_hword <= n_hword;
        end
    end

    // Stage 1: frame result with the raw words.
    logic        r_s1_valid;
    t_status     r_s1_status;
    logic [15:0] r_s1_tword;
    logic [15:0] r_s1_hword;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_en) begin
            r_s1_valid <= n_emit;
        end
        if (w_en) begin
            r_s1_status <= n_status;
            r_s1_tword  <= r_tword;
            r_s1_hword  <= r_hword;
        end
    end

    // Stage 2: scale the raw words by the output spans.
    logic        r_s2_valid;
    t_status     r_s2_status;
    logic [30:0] r_s2_tprod;
    logic [29:0] r_s2_hprod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_en) begin
            r_s2_valid <= r_s1_valid;
        end
        if (w_en) begin
            r_s2_status <= r_s1_status;
            r_s2_tprod  <= 31'(r_s1_tword) * 31'(TEMP_SPAN);
            r_s2_hprod  <= 30'(r_s1_hword) * 30'(HUM_SPAN);
        end
    end

    // Divide by 65535: the quotient estimate x >> 16 leaves a remainder of
    // (x mod 65536) + estimate, which stays below twice the divisor.
    logic [14:0] w_tq0, w_tq, w_temp;
    logic [16:0] w_trem;
    logic [13:0] w_hq0, w_hq;
    logic [16:0] w_hrem;

    always_comb begin
        w_tq0  = r_s2_tprod[30:16];
        w_trem = {1'b0, r_s2_tprod[15:0]} + 17'(w_tq0);
        w_tq   = w_tq0 + 15'(w_trem >= WORD_FULL);
        w_temp = w_tq - TEMP_OFFSET;
        w_hq0  = r_s2_hprod[29:16];
        w_hrem = {1'b0, r_s2_hprod[15:0]} + 17'(w_hq0);
        w_hq   = w_hq0 + 14'(w_hrem >= WORD_FULL);
    end

    // Output register; values read zero unless the frame passed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= r_s2_valid;
        end
        if (w_en) begin
            r_out_status <= r_s2_status;
            r_out_temp   <= (r_s2_status == ST_OK) ? w_temp : 15'd0;
            r_out_hum    <= (r_s2_status == ST_OK) ? w_hq : 14'd0;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_status;
    assign o_m_axis_tdata  = {3'd0, r_out_hum, r_out_temp};

endmodule

/* rtl/hsfc_checker.sv */
// Port-level checks for the humidity sensor frame checker, bound to the top level.
module hsfc_checker
    import hsfc_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [31:0] o_m_axis_tdata,
    input logic [2:0]  o_m_axis_tuser
);

    // A stalled result stays offered with the same contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("result changed while stalled");

    // The input side is ready exactly when the output register can move.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready == (!o_m_axis_tvalid || i_m_axis_tready))
        else $error("input ready does not follow output stall");

    // Any failed frame reports zero values.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser != ST_OK) |-> o_m_axis_tdata == 32'd0)
        else $error("nonzero values with error status");

    // Converted humidity never exceeds full scale.
    a_hum_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[28:15] <= 14'd10000 && o_m_axis_tdata[31:29] == 3'd0)
        else $error("humidity out of range");

    // Reset empties the output register.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind humidity_sensor_frame_checker hsfc_checker u_hsfc_checker (.*);
